/* rtl/core/fmpm_pkg.sv */
package fmpm_pkg;

  localparam int unsigned REG_COUNT = 8;
  localparam logic [31:0] BASE_CAP = 32'd2104533975;
  localparam logic signed [15:0] SYNC_THRESHOLD = 16'sd8192;
  localparam logic signed [15:0] CV_MAX = 16'sd16384;
  localparam logic signed [15:0] CV_MIN = -16'sd16384;
  localparam logic [15:0] FB_SCALE = 16'd11796;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_LOOK,
    STEP_RATIO,
    STEP_BASE,
    STEP_ADV,
    STEP_SYNC,
    STEP_MOD,
    STEP_FB,
    STEP_ACC,
    STEP_SIN,
    STEP_LVL,
    STEP_MIX,
    STEP_GAIN,
    STEP_OUT
  } step_t;

  typedef struct packed {
    step_t      step;
    logic [1:0] d;
    logic [1:0] s;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  typedef struct packed {
    logic [31:0]            base;
    logic [15:0]            gain;
    logic [3:0][15:0]       ratio;
    logic [3:0][15:0]       detune;
    logic [3:0][15:0]       level;
    logic [3:0][3:0][15:0]  depth;
  } cfg_t;

  // Mantissa table entry: round(2^15 * 2^(k / 2^bits)) by power series.
  function automatic logic [15:0] exp_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y = (LN2_Q30 * 64'(k)) >> bits;
    term = 64'd1 << 30;
    sum = term;
    for (int unsigned n = 1; n <= 20; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum = sum + term;
    end
    return 16'((sum + (64'd1 << 14)) >> 15);
  endfunction

  // Sine table entry in Q1.14, built per quadrant by power series.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
    int unsigned qb;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint s;
    longint c;
    longint v;
    qb = bits - 2;
    q = (64'(k) >> qb) & 64'd3;
    r = 64'(k) & ((64'd1 << qb) - 64'd1);
    x = (HALFPI_Q30 * r) >> qb;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s = 0;
    c = 0;
    for (int unsigned n = 0; n < 12; n++) begin
      if (n[0]) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
      ts = ((ts * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
      tc = ((tc * x2) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
    end
    v = q[0] ? c : s;
    if (v < 0) begin
      v = 0;
    end
    v = (v + 32768) >>> 16;
    if (v > 16384) begin
      v = 16384;
    end
    return q[1] ? 16'(-v) : 16'(v);
  endfunction

endpackage

/* rtl/core/fmpm_regs.sv */
module fmpm_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output fmpm_pkg::cfg_t       cfg
);

  logic [7:0][63:0] regs_r;
  logic [2:0]       idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = regs_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (idx == 3'd0) begin
        regs_r[idx] <= {16'd0, pwdata[47:0]};
      end else begin
        regs_r[idx] <= pwdata;
      end
    end
  end

  assign cfg.base   = regs_r[0][31:0];
  assign cfg.gain   = regs_r[0][47:32];
  assign cfg.ratio  = regs_r[1];
  assign cfg.detune = regs_r[2];
  assign cfg.level  = regs_r[3];
  assign cfg.depth  = regs_r[7:4];

endmodule

/* rtl/core/fmpm_dp.sv */
module fmpm_dp #(
  parameter int unsigned OCTAVE_SPAN     = 10,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned EXP_TABLE_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fmpm_pkg::cmd_t         cmd,
  output fmpm_pkg::status_t      status,
  input  fmpm_pkg::cfg_t         cfg,
  input  logic signed [15:0]     in_pitch_cv,
  input  logic signed [15:0]     in_sync_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [23:0]     out_audio_out
);

  localparam int unsigned SINE_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int unsigned EXP_DEPTH  = 1 << EXP_TABLE_BITS;

  logic [15:0] sine_rom [SINE_DEPTH];
  logic [15:0] exp_rom  [EXP_DEPTH];

  for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_sine
    assign sine_rom[k] = fmpm_pkg::sine_entry(k, SINE_TABLE_BITS);
  end
  for (genvar k = 0; k < EXP_DEPTH; k++) begin : g_exp
    assign exp_rom[k] = fmpm_pkg::exp_entry(k, EXP_TABLE_BITS);
  end

  logic signed [15:0] cv_r;
  logic signed [15:0] sync_r;
  logic               was_r;
  logic               edge_r;
  logic [15:0]        mant_r;
  logic [5:0]         shift_r;
  logic [31:0]        phase_r [4];
  logic signed [15:0] prev_r [4];
  logic signed [15:0] new_r [4];
  logic [31:0]        sum_r;
  logic signed [32:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [15:0] sine_cur_r;
  logic signed [23:0] out_r;
  logic               out_valid_r;

  logic signed [15:0] cv_cl;
  logic signed [20:0] e_val;
  logic signed [6:0]  ip;
  logic signed [6:0]  shift_val;
  logic               sync_high;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [31:0]        base_cap;
  logic [15:0]        ratio_d;
  logic [15:0]        det_d;
  logic [15:0]        level_d;
  logic [15:0]        depth_sd;
  logic [31:0]        inc;
  logic [31:0]        term;
  logic [31:0]        arg;
  logic signed [65:0] y_full;

  always_comb begin
    if (cv_r > fmpm_pkg::CV_MAX) begin
      cv_cl = fmpm_pkg::CV_MAX;
    end else if (cv_r < fmpm_pkg::CV_MIN) begin
      cv_cl = fmpm_pkg::CV_MIN;
    end else begin
      cv_cl = cv_r;
    end
  end

  assign e_val     = 21'(cv_cl) * $signed(21'(OCTAVE_SPAN));
  assign ip        = 7'(e_val >>> 14);
  assign shift_val = 7'sd23 - ip;
  assign sync_high = sync_r > fmpm_pkg::SYNC_THRESHOLD;

  assign base_cap = (cfg.base > fmpm_pkg::BASE_CAP) ? fmpm_pkg::BASE_CAP : cfg.base;
  assign ratio_d  = cfg.ratio[cmd.d];
  assign det_d    = cfg.detune[cmd.d];
  assign level_d  = cfg.level[cmd.d];
  assign depth_sd = cfg.depth[cmd.s][cmd.d];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      fmpm_pkg::STEP_RATIO: begin
        mul_a = {17'd0, ratio_d};
        mul_b = {17'd0, mant_r};
      end
      fmpm_pkg::STEP_BASE: begin
        mul_a = {1'b0, base_cap};
        mul_b = {1'b0, prod_r[31:0]};
      end
      fmpm_pkg::STEP_MOD: begin
        mul_a = {{17{depth_sd[15]}}, depth_sd};
        mul_b = {{17{prev_r[cmd.s][15]}}, prev_r[cmd.s]};
      end
      fmpm_pkg::STEP_FB: begin
        mul_a = prod_r[32:0];
        mul_b = {17'd0, fmpm_pkg::FB_SCALE};
      end
      fmpm_pkg::STEP_LVL: begin
        mul_a = {{17{level_d[15]}}, level_d};
        mul_b = {{17{sine_cur_r[15]}}, sine_cur_r};
      end
      fmpm_pkg::STEP_GAIN: begin
        mul_a = acc_r;
        mul_b = {{17{cfg.gain[15]}}, cfg.gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign inc    = 32'(prod_r[63:0] >> shift_r) + {{12{det_d[15]}}, det_d, 4'd0};
  assign term   = (cmd.s == cmd.d) ? 32'(prod_r >>> 11) : {prod_r[26:0], 5'd0};
  assign arg    = phase_r[cmd.d] + sum_r;
  assign y_full = prod_r >>> 20;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        phase_r[i] <= '0;
        prev_r[i]  <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && cmd.step != fmpm_pkg::STEP_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.step)
        fmpm_pkg::STEP_LOAD: begin
          cv_r   <= in_pitch_cv;
          sync_r <= in_sync_level;
        end
        fmpm_pkg::STEP_LOOK: begin
          mant_r  <= exp_rom[e_val[13 -: EXP_TABLE_BITS]];
          shift_r <= 6'(shift_val);
          edge_r  <= sync_high && !was_r;
          was_r   <= sync_high;
        end
        fmpm_pkg::STEP_RATIO, fmpm_pkg::STEP_BASE, fmpm_pkg::STEP_MOD,
        fmpm_pkg::STEP_FB, fmpm_pkg::STEP_LVL, fmpm_pkg::STEP_GAIN: begin
          prod_r <= mul_p;
          if (cmd.step == fmpm_pkg::STEP_LVL) begin
            new_r[cmd.d] <= sine_cur_r;
          end
        end
        fmpm_pkg::STEP_ADV: begin
          phase_r[cmd.d] <= phase_r[cmd.d] + inc;
        end
        fmpm_pkg::STEP_SYNC: begin
          if (edge_r) begin
            for (int i = 0; i < 4; i++) begin
              phase_r[i] <= '0;
            end
          end
          sum_r <= '0;
          acc_r <= '0;
        end
        fmpm_pkg::STEP_ACC: begin
          sum_r <= sum_r + term;
        end
        fmpm_pkg::STEP_SIN: begin
          sine_cur_r <= sine_rom[arg[31 -: SINE_TABLE_BITS]];
        end
        fmpm_pkg::STEP_MIX: begin
          acc_r <= acc_r + prod_r[32:0];
          sum_r <= '0;
        end
        fmpm_pkg::STEP_OUT: begin
          if (y_full > 66'(fmpm_pkg::OUT_MAX)) begin
            out_r <= fmpm_pkg::OUT_MAX;
          end else if (y_full < 66'(fmpm_pkg::OUT_MIN)) begin
            out_r <= fmpm_pkg::OUT_MIN;
          end else begin
            out_r <= 24'(y_full);
          end
          out_valid_r <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            prev_r[i] <= new_r[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_audio_out      = out_r;

endmodule

/* rtl/core/fmpm_ctrl.sv */
module fmpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmpm_pkg::status_t   status,
  output fmpm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_RATIO, S_BASE, S_ADV, S_SYNC, S_MOD,
    S_FB, S_ACC, S_SIN, S_LVL, S_MIX, S_GAIN, S_OUT
  } state_t;

  state_t     state_r;
  logic [1:0] d_r;
  logic [1:0] s_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.d = d_r;
    cmd.s = s_r;
    case (state_r)
      S_IDLE:  cmd.step = in_valid ? fmpm_pkg::STEP_LOAD : fmpm_pkg::STEP_NONE;
      S_LOOK:  cmd.step = fmpm_pkg::STEP_LOOK;
      S_RATIO: cmd.step = fmpm_pkg::STEP_RATIO;
      S_BASE:  cmd.step = fmpm_pkg::STEP_BASE;
      S_ADV:   cmd.step = fmpm_pkg::STEP_ADV;
      S_SYNC:  cmd.step = fmpm_pkg::STEP_SYNC;
      S_MOD:   cmd.step = fmpm_pkg::STEP_MOD;
      S_FB:    cmd.step = fmpm_pkg::STEP_FB;
      S_ACC:   cmd.step = fmpm_pkg::STEP_ACC;
      S_SIN:   cmd.step = fmpm_pkg::STEP_SIN;
      S_LVL:   cmd.step = fmpm_pkg::STEP_LVL;
      S_MIX:   cmd.step = fmpm_pkg::STEP_MIX;
      S_GAIN:  cmd.step = fmpm_pkg::STEP_GAIN;
      S_OUT:   cmd.step = status.out_blocked ? fmpm_pkg::STEP_NONE : fmpm_pkg::STEP_OUT;
      default: cmd.step = fmpm_pkg::STEP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      d_r     <= '0;
      s_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          d_r     <= '0;
          state_r <= S_RATIO;
        end
        S_RATIO: state_r <= S_BASE;
        S_BASE:  state_r <= S_ADV;
        S_ADV: begin
          d_r <= d_r + 2'd1;
          if (d_r == 2'd3) begin
            state_r <= S_SYNC;
          end else begin
            state_r <= S_RATIO;
          end
        end
        S_SYNC: begin
          s_r     <= '0;
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (s_r == d_r) begin
            state_r <= S_FB;
          end else begin
            state_r <= S_ACC;
          end
        end
        S_FB: state_r <= S_ACC;
        S_ACC: begin
          s_r <= s_r + 2'd1;
          if (s_r == 2'd3) begin
            state_r <= S_SIN;
          end else begin
            state_r <= S_MOD;
          end
        end
        S_SIN: state_r <= S_LVL;
        S_LVL: state_r <= S_MIX;
        S_MIX: begin
          if (d_r == 2'd3) begin
            state_r <= S_GAIN;
          end else begin
            d_r     <= d_r + 2'd1;
            state_r <= S_MOD;
          end
        end
        S_GAIN: state_r <= S_OUT;
        S_OUT: begin
          if (!status.out_blocked) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_LOOK))
    else $error("accepted beat did not start the lookup step");

  a_adv_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV && d_r == 2'd3) |=> (state_r == S_SYNC && d_r == 2'd0))
    else $error("phase advance did not finish after the last operator");

  a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !status.out_blocked) |=> (state_r == S_IDLE))
    else $error("result write did not return to idle");

  a_fb_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FB) |-> (s_r == d_r))
    else $error("feedback scaling used off the diagonal");
`endif

endmodule

/* rtl/core/four_op_phase_mod_matrix_voice.sv */
// in_stall is high while the sequencer is busy, so a new input beat is taken only
// once it is idle again; a single shared 33x33 multiplier is stepped through
// the phase increments, the 16 modulation terms and the mix by the sequencer.
// A waiting result does not block the next input beat once the sequencer is idle.
// Reset (rst_n low, synchronous) clears phases, last sines, sync history, all
// configuration registers and the output valid flag.
module four_op_phase_mod_matrix_voice #(
  parameter int unsigned OCTAVE_SPAN     = 10,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned EXP_TABLE_BITS  = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pitch_cv,
  input  logic signed [15:0] in_sync_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_audio_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  // Configuration registers sit at 8-byte strides; register 0 keeps 48 bits.
  fmpm_pkg::cfg_t    cfg;
  fmpm_pkg::cmd_t    cmd;
  fmpm_pkg::status_t status;

  fmpm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller walks the operators: four increment updates, then for each
  // destination the four modulation terms, the sine lookup and the level mix.
  fmpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the phase accumulators, the sine and exponent tables,
  // the shared multiplier and the output register.
  fmpm_dp #(
    .OCTAVE_SPAN     (OCTAVE_SPAN),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .EXP_TABLE_BITS  (EXP_TABLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .in_pitch_cv   (in_pitch_cv),
    .in_sync_level (in_sync_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_audio_out (out_audio_out)
  );

endmodule
